[hw/rtl/lpr_pkg.sv]
package lpr_pkg;

    // Field widths fixed by the pixel stream format.
    localparam int X_W     = 9;
    localparam int Y_W     = 8;
    localparam int COLOR_W = 16;
    localparam int ADDR_W  = 32;

    // Internal coordinate width: one bit above the widest field, so that the
    // walk along either axis never wraps.
    localparam int COORD_W = X_W + 1;
    // Signed difference of two coordinates, with headroom.
    localparam int DELTA_W = COORD_W + 1;
    // Running remainder plus delta before the correction step.
    localparam int SUM_W   = COORD_W + 2;

    // Default row pitch of the frame buffer, as a left shift of the row.
    localparam int ROW_SHIFT_DEF = 10;

    // Command codes.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [X_W-1:0]     x_start;
        logic [Y_W-1:0]     y_start;
        logic [X_W-1:0]     x_end;
        logic [Y_W-1:0]     y_end;
        logic [COLOR_W-1:0] line_color;
    } t_line_cmd;

    typedef struct packed {
        logic [X_W-1:0]     pixel_x;
        logic [Y_W-1:0]     pixel_y;
        logic [ADDR_W-1:0]  byte_addr;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } t_pixel;

    // Pixel handed from the line stepper to the output stage.
    typedef struct packed {
        logic               emit;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_step_pixel;

endpackage

[hw/rtl/lpr_stream_if.sv]
interface lpr_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/lpr_line_stepper.sv]
module lpr_line_stepper
    import lpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_line_cmd   i_cmd,
    output t_step_pixel o_step
);

    logic                      r_active, n_active;
    logic                      r_steep;
    logic                      r_step_down;
    logic [COORD_W-1:0]        r_major_pos;
    logic [COORD_W-1:0]        r_major_end;
    logic [COORD_W-1:0]        r_minor_pos;
    logic [COORD_W-1:0]        r_remainder;
    logic signed [DELTA_W-1:0] r_minor_delta;
    logic [COORD_W-1:0]        r_span;
    logic [COLOR_W-1:0]        r_color;

    logic                      is_start;
    logic                      is_step;
    logic                      last;

    // Line setup from the two endpoints.
    logic signed [DELTA_W-1:0] dx, dy, adx, ady;
    logic                      steep;

    // Running quotient and remainder update.
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   span_s;
    logic signed [SUM_W-1:0]   rem_fix;
    logic [COORD_W-1:0]        n_minor_pos;
    logic [COORD_W-1:0]        n_major_pos;

    assign dx = $signed({{(DELTA_W-X_W){1'b0}}, i_cmd.x_end})
              - $signed({{(DELTA_W-X_W){1'b0}}, i_cmd.x_start});
    assign dy = $signed({{(DELTA_W-Y_W){1'b0}}, i_cmd.y_end})
              - $signed({{(DELTA_W-Y_W){1'b0}}, i_cmd.y_start});
    assign adx   = dx[DELTA_W-1] ? -dx : dx;
    assign ady   = dy[DELTA_W-1] ? -dy : dy;
    assign steep = ady > adx;

    assign is_start = i_accept && (i_cmd.opcode == OP_START);
    assign is_step  = i_accept && (i_cmd.opcode == OP_ADVANCE) && r_active;
    assign last     = (r_major_pos == r_major_end);

    assign sum    = $signed({2'b00, r_remainder})
                  + $signed({{(SUM_W-DELTA_W){r_minor_delta[DELTA_W-1]}}, r_minor_delta});
    assign span_s = $signed({2'b00, r_span});

    always_comb begin
        rem_fix     = sum;
        n_minor_pos = r_minor_pos;
        if (sum >= span_s) begin
            rem_fix     = sum - span_s;
            n_minor_pos = r_minor_pos + COORD_W'(1);
        end else if (sum < 0) begin
            rem_fix     = sum + span_s;
            n_minor_pos = r_minor_pos - COORD_W'(1);
        end
        n_major_pos = r_step_down ? r_major_pos - COORD_W'(1) : r_major_pos + COORD_W'(1);
    end

    always_comb begin
        n_active = r_active;
        if (is_start) begin
            n_active = 1'b1;
        end else if (is_step && last) begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_start) begin
            r_steep     <= steep;
            r_color     <= i_cmd.line_color;
            r_remainder <= '0;
            if (steep) begin
                r_major_pos   <= {{(COORD_W-Y_W){1'b0}}, i_cmd.y_start};
                r_major_end   <= {{(COORD_W-Y_W){1'b0}}, i_cmd.y_end};
                r_step_down   <= i_cmd.y_end < i_cmd.y_start;
                r_span        <= ady[COORD_W-1:0];
                r_minor_pos   <= {{(COORD_W-X_W){1'b0}}, i_cmd.x_start};
                r_minor_delta <= dx;
            end else begin
                r_major_pos   <= {{(COORD_W-X_W){1'b0}}, i_cmd.x_start};
                r_major_end   <= {{(COORD_W-X_W){1'b0}}, i_cmd.x_end};
                r_step_down   <= i_cmd.x_end < i_cmd.x_start;
                r_span        <= adx[COORD_W-1:0];
                r_minor_pos   <= {{(COORD_W-Y_W){1'b0}}, i_cmd.y_start};
                r_minor_delta <= dy;
            end
        end else if (is_step && !last) begin
            r_major_pos <= n_major_pos;
            r_minor_pos <= n_minor_pos;
            r_remainder <= rem_fix[COORD_W-1:0];
        end
    end

    assign o_step.emit  = is_step;
    assign o_step.x     = r_steep ? r_minor_pos[X_W-1:0] : r_major_pos[X_W-1:0];
    assign o_step.y     = r_steep ? r_major_pos[Y_W-1:0] : r_minor_pos[Y_W-1:0];
    assign o_step.color = r_color;
    assign o_step.last  = last;

endmodule

[hw/rtl/lpr_pixel_out.sv]
module lpr_pixel_out
    import lpr_pkg::*;
#(
    parameter int ROW_SHIFT = ROW_SHIFT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [ADDR_W-1:0]   i_cfg_wdata,
    input  t_step_pixel         i_step,
    output logic                o_can_take,
    lpr_stream_if.source        o_pix
);

    logic [ADDR_W-1:0] r_base;
    logic              r_valid, n_valid;
    t_pixel            r_pixel;
    logic [ADDR_W-1:0] row_ofs, col_ofs;

    assign row_ofs = {{(ADDR_W-Y_W){1'b0}}, i_step.y} << ROW_SHIFT;
    assign col_ofs = {{(ADDR_W-X_W){1'b0}}, i_step.x} << 1;

    assign o_can_take = !r_valid || o_pix.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_step.emit) begin
            n_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_base  <= '0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.emit) begin
            r_pixel.pixel_x     <= i_step.x;
            r_pixel.pixel_y     <= i_step.y;
            r_pixel.byte_addr   <= r_base + row_ofs + col_ofs;
            r_pixel.pixel_color <= i_step.color;
            r_pixel.last_pixel  <= i_step.last;
        end
    end

    assign o_pix.valid   = r_valid;
    assign o_pix.payload = r_pixel;

endmodule

[hw/rtl/line_pixel_rasterizer_unit.sv]
// Channel   Direction  Payload      Meaning
// i_cmd     in         t_line_cmd   start a line (endpoints, color) or advance one pixel
// o_pix     out        t_pixel      one frame-buffer pixel write with its byte address
// i_cfg_*   in         32 bits      frame buffer base address, write only
//
// A new command is accepted in every cycle in which o_pix is not stalled.
// An advance on an active line puts its pixel on o_pix in the cycle after acceptance,
// so unstalled advances yield one pixel per cycle, set by the single result register.
// Reset (synchronous, active low) drops any active line, empties the result register
// and clears the base address. A stalled o_pix holds its pixel, and i_cmd is then
// ready only in the cycle in which that pixel is taken.
module line_pixel_rasterizer_unit
    import lpr_pkg::*;
#(
    parameter int ROW_SHIFT = ROW_SHIFT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_wdata,
    lpr_stream_if.sink        i_cmd,
    lpr_stream_if.source      o_pix
);

    // A command is taken whenever the result register is empty or is being
    // emptied in the same cycle, so a pixel that leaves the register frees it
    // for the next one without a gap.
    logic        can_take;
    logic        cmd_accept;
    t_step_pixel step;

    assign i_cmd.ready = can_take;
    assign cmd_accept  = i_cmd.valid && can_take;

    // The stepper holds the line state. A start loads it; an advance reads the
    // current pixel from it and moves the major coordinate one step, updating the
    // minor coordinate through an exact running remainder (no divider needed).
    lpr_line_stepper u_stepper (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (cmd_accept),
        .i_cmd    (i_cmd.payload),
        .o_step   (step)
    );

    // The output stage forms the byte address from the base register and the
    // pixel coordinates, and holds the result until the sink takes it.
    lpr_pixel_out #(
        .ROW_SHIFT (ROW_SHIFT)
    ) u_pixel_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (step),
        .o_can_take  (can_take),
        .o_pix       (o_pix)
    );

endmodule
